// ===== rtl/mbsp_pkg.sv =====
// Shared types, byte codes and helper functions for the MIDI byte stream parser.
package mbsp_pkg;

   // Default exclusive message capacity in bytes
   localparam int SYSEX_CAPACITY_DEF = 4096;

   // Width of the packed result fields
   localparam int SHORT_W = 24;
   localparam int POS_W   = 12;

   // Stream byte codes
   localparam logic [7:0] BYTE_F0 = 8'hF0;
   localparam logic [7:0] BYTE_F1 = 8'hF1;
   localparam logic [7:0] BYTE_F2 = 8'hF2;
   localparam logic [7:0] BYTE_F3 = 8'hF3;
   localparam logic [7:0] BYTE_F6 = 8'hF6;
   localparam logic [7:0] BYTE_F7 = 8'hF7;
   localparam logic [7:0] BYTE_F8 = 8'hF8;
   localparam logic [7:0] BYTE_FA = 8'hFA;
   localparam logic [7:0] BYTE_FB = 8'hFB;
   localparam logic [7:0] BYTE_FC = 8'hFC;
   localparam logic [7:0] BYTE_FE = 8'hFE;
   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] NO_STATUS = 8'h00;

   // Parser mode
   typedef enum logic [1:0] {
      MODE_READY   = 2'd0,
      MODE_CHANNEL = 2'd1,
      MODE_EXCL    = 2'd2,
      MODE_COMMON  = 2'd3
   } mode_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_TAKEN    = 3'd0,
      KIND_SHORT    = 3'd1,
      KIND_SX_BYTE  = 3'd2,
      KIND_SX_END   = 3'd3,
      KIND_SX_ABORT = 3'd4,
      KIND_REALTIME = 3'd5,
      KIND_UNDEF    = 3'd6,
      KIND_CLOSED   = 3'd7
   } kind_type;

   // Parser state apart from the byte counter
   typedef struct packed {
      mode_type   mode;
      logic [7:0] run_status;
      logic [7:0] held0;
      logic [7:0] held1;
   } st_type;

   // One result beat
   typedef struct packed {
      kind_type           kind;
      logic [SHORT_W-1:0] short_message;
      logic [7:0]         sysex_data;
      logic [POS_W-1:0]   sysex_position;
   } res_type;

   // Real-time bytes pass through every mode untouched
   function automatic logic is_realtime(input logic [7:0] b);
      return (b inside {BYTE_F8, BYTE_FA, BYTE_FB, BYTE_FC, BYTE_FE, BYTE_FF});
   endfunction

   // Total message length for a given status byte
   function automatic logic [1:0] msg_len(input logic [7:0] status);
      logic [1:0] len;
      if (status < BYTE_F0) begin
         len = (status[7:5] == 3'b110) ? 2'd2 : 2'd3;
      end else begin
         len = (status == BYTE_F2) ? 2'd3 : 2'd2;
      end
      return len;
   endfunction

endpackage

// ===== rtl/mbsp_decoder.sv =====
// Per-byte decode: next parser state and the result for one stream byte.
module mbsp_decoder import mbsp_pkg::*; #(
   parameter int SYSEX_CAPACITY = SYSEX_CAPACITY_DEF,
   localparam int CNT_W = $clog2(SYSEX_CAPACITY + 1)
) (
   input  logic             port_open,
   input  logic [7:0]       in_byte,
   input  st_type           st_cur,
   input  logic [CNT_W-1:0] cnt_cur,
   output st_type           st_nxt,
   output logic [CNT_W-1:0] cnt_nxt,
   output res_type          res
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SYSEX_CAPACITY);

   logic [CNT_W+POS_W-1:0] cnt_ext;
   logic [CNT_W-1:0]       cnt_inc;
   logic [7:0]             held0_v;
   logic [1:0]             cnt_v;
   mode_type               mode_v;
   logic                   data_live;

   assign cnt_ext = {{POS_W{1'b0}}, cnt_cur};
   assign cnt_inc = cnt_cur + CNT_W'(1);

   always_comb begin
      st_nxt    = st_cur;
      cnt_nxt   = cnt_cur;
      res       = '{kind: KIND_TAKEN, default: '0};
      held0_v   = st_cur.held0;
      cnt_v     = cnt_cur[1:0];
      mode_v    = st_cur.mode;
      data_live = 1'b1;

      if (!port_open) begin
         res.kind = KIND_CLOSED;
      end else if (is_realtime(in_byte)) begin
         res.kind = KIND_REALTIME;
      end else if (st_cur.mode == MODE_EXCL) begin
         // exclusive body: forward every byte but real-time ones with its position
         res.sysex_data     = in_byte;
         res.sysex_position = cnt_ext[POS_W-1:0];
         cnt_nxt            = cnt_inc;
         if (in_byte == BYTE_F7) begin
            res.kind    = KIND_SX_END;
            st_nxt.mode = MODE_READY;
            cnt_nxt     = '0;
         end else if (cnt_inc >= CAP_CNT) begin
            res.kind    = KIND_SX_ABORT;
            st_nxt.mode = MODE_READY;
            cnt_nxt     = '0;
         end else begin
            res.kind = KIND_SX_BYTE;
         end
      end else if (in_byte[7]) begin
         // status byte starts a new message; tune request and undefined ones return to ready
         if (in_byte < BYTE_F0) begin
            st_nxt.run_status = in_byte;
            st_nxt.held0      = in_byte;
            st_nxt.mode       = MODE_CHANNEL;
            cnt_nxt           = CNT_W'(1);
         end else begin
            st_nxt.run_status = NO_STATUS;
            case (in_byte)
               BYTE_F0: begin
                  st_nxt.mode        = MODE_EXCL;
                  cnt_nxt            = CNT_W'(1);
                  res.kind           = KIND_SX_BYTE;
                  res.sysex_data     = in_byte;
               end
               BYTE_F1, BYTE_F2, BYTE_F3: begin
                  st_nxt.held0 = in_byte;
                  st_nxt.mode  = MODE_COMMON;
                  cnt_nxt      = CNT_W'(1);
               end
               BYTE_F6: begin
                  st_nxt.mode = MODE_READY;
                  cnt_nxt     = '0;
               end
               default: begin
                  st_nxt.mode = MODE_READY;
                  cnt_nxt     = '0;
                  res.kind    = KIND_UNDEF;
               end
            endcase
         end
      end else begin
         // data byte; in ready it reuses running status if there is one
         if (st_cur.mode == MODE_READY) begin
            if (st_cur.run_status == NO_STATUS) begin
               data_live = 1'b0;
            end else begin
               held0_v = st_cur.run_status;
               cnt_v   = 2'd1;
               mode_v  = MODE_CHANNEL;
            end
         end
         if (data_live) begin
            st_nxt.held0 = held0_v;
            if (({1'b0, cnt_v} + 3'd1) >= {1'b0, msg_len(held0_v)}) begin
               if (mode_v == MODE_CHANNEL) begin
                  res.kind = KIND_SHORT;
                  if (cnt_v >= 2'd2) begin
                     res.short_message = {in_byte, st_cur.held1, held0_v};
                  end else begin
                     res.short_message = {8'h00, in_byte, held0_v};
                  end
               end
               st_nxt.mode = MODE_READY;
               cnt_nxt     = '0;
            end else begin
               st_nxt.held1 = in_byte;
               st_nxt.mode  = mode_v;
               cnt_nxt      = CNT_W'(cnt_v) + CNT_W'(1);
            end
         end
      end
   end

endmodule

// ===== rtl/midi_byte_stream_parser.sv =====
// Top level of the MIDI byte stream parser: state registers, output register and skid beat.
//
//   channel   dir  width  contents
//   req_*     in   8      tdata: in_byte
//   rsp_*     out  48/3   tdata: short_message, sysex_data, sysex_position; tuser: result_kind
//   csr_*     in   1      port_open
//
// Each accepted byte gives exactly one result beat, registered into the output register or the skid beat.
// Sustained rate is one byte per cycle while rsp_tready stays high; the decode is a single pass of
// logic between the parser state registers and the output register.
// A skid beat behind the output register keeps req_tready registered; it drops only when
// both hold a result. Reset is synchronous and returns the parser to ready, port closed.
module midi_byte_stream_parser import mbsp_pkg::*; #(
   parameter int SYSEX_CAPACITY = SYSEX_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] short_message, [31:24] sysex_data,
                                    // [43:32] sysex_position, [47:44] zero
   output logic [2:0]  rsp_tuser,   // [2:0] result_kind
   input  logic        csr_wen,
   input  logic        csr_wdata    // port_open
);

   localparam int CNT_W = $clog2(SYSEX_CAPACITY + 1);

   logic             port_open_ff;
   st_type           st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   res_type          res_in;
   res_type          out_ff, skid_ff;
   logic             out_vld_ff, skid_vld_ff;
   logic             acc, take;

   assign req_tready = !skid_vld_ff;
   assign acc        = req_tvalid && req_tready;
   assign take       = out_vld_ff && rsp_tready;

   // decode of the incoming byte
   mbsp_decoder #(
      .SYSEX_CAPACITY(SYSEX_CAPACITY)
   ) u_decoder (
      .port_open(port_open_ff),
      .in_byte  (req_tdata),
      .st_cur   (st_ff),
      .cnt_cur  (cnt_ff),
      .st_nxt   (st_in),
      .cnt_nxt  (cnt_in),
      .res      (res_in)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         port_open_ff <= 1'b0;
      end else if (csr_wen) begin
         port_open_ff <= csr_wdata;
      end
   end

   // parser state advances on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= '{mode: MODE_READY, default: '0};
         cnt_ff <= '0;
      end else if (acc) begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
   end

   // output register and skid valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (take) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= acc;
         end
      end else if (acc) begin
         if (out_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      if (take) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else if (acc) begin
            out_ff <= res_in;
         end
      end else if (acc) begin
         if (out_vld_ff) begin
            skid_ff <= res_in;
         end else begin
            out_ff <= res_in;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {4'b0000, out_ff.sysex_position, out_ff.sysex_data,
                        out_ff.short_message};

endmodule

// ===== rtl/mbsp_checker.sv =====
// Port-level checks for the MIDI byte stream parser, bound to the top level.
module mbsp_checker import mbsp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // reset empties the output side and opens the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not empty after reset");

   // message field only carries a channel message, whose low byte is a status
   a_short_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_SHORT) ? rsp_tdata[7]
                                               : (rsp_tdata[23:0] == 24'h0))
      else $error("short message field inconsistent with kind");

   // exclusive fields and padding are zero outside exclusive kinds
   a_sysex_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_TAKEN || rsp_tuser == KIND_SHORT ||
                     rsp_tuser == KIND_REALTIME || rsp_tuser == KIND_UNDEF ||
                     rsp_tuser == KIND_CLOSED)
      |-> rsp_tdata[47:24] == 24'h0)
      else $error("exclusive fields set for a non-exclusive kind");

   // input stays closed while both result beats are held and the output is stalled
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !req_tready |=> !req_tready)
      else $error("input reopened with both result beats still held");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

// ===== verif/tb_top.sv =====
// Self-checking stream testbench for the MIDI byte stream parser.
`timescale 1ns / 1ps

module tb_top import mbsp_pkg::*;;

   localparam int CAPACITY   = SYSEX_CAPACITY_DEF;
   localparam int HOLD_AFTER = 300;   // result beats seen before the long hold-off
   localparam int HOLD_LEN   = 150;   // hold-off length in cycles

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [23:0] short_message, [31:24] sysex_data,
                                      // [43:32] sysex_position
   logic [2:0]  rsp_tuser;            // [2:0] result_kind
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;     // port_open

   // parser state as the checker sees it
   logic       open_q;
   mode_type   mode_q;
   logic [7:0] run_status_q;
   logic [7:0] held0_q;
   logic [7:0] held1_q;
   int         count_q;

   logic [7:0] pending_bytes[$];      // beats waiting for the driver
   res_type    results_due[$];        // predicted result beats, oldest first
   res_type    due_now;
   int         errors = 0;
   int         beats_seen = 0;
   int         stim_count = 0;
   logic [7:0] last_status = 8'h90;
   bit         steady = 1'b0;         // no idling on either side while set
   bit         hold_done = 1'b0;
   int         stall_left = 0;

   midi_byte_stream_parser #(.SYSEX_CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // length of a channel message, status included
   function automatic int chan_len(input logic [7:0] status);
      return ((status & 8'hE0) == 8'hC0) ? 2 : 3;
   endfunction

   // advance the parser state by one byte and give the result beat it causes
   function automatic res_type parse_byte(input logic [7:0] b);
      res_type r;
      int      need;
      r = '0;
      r.kind = KIND_TAKEN;
      if (!open_q) begin
         r.kind = KIND_CLOSED;
         return r;
      end
      case (b)
         BYTE_F8, BYTE_FA, BYTE_FB, BYTE_FC, BYTE_FE, BYTE_FF: begin
            r.kind = KIND_REALTIME;
            return r;
         end
         default: ;
      endcase

      // inside exclusive every byte but real-time ones is forwarded with its position
      if (mode_q == MODE_EXCL) begin
         r.sysex_data = b;
         r.sysex_position = count_q[POS_W-1:0];
         count_q++;
         if (b == BYTE_F7) begin
            r.kind = KIND_SX_END;
            mode_q = MODE_READY;
            count_q = 0;
         end else if (count_q >= CAPACITY) begin
            r.kind = KIND_SX_ABORT;
            mode_q = MODE_READY;
            count_q = 0;
         end else begin
            r.kind = KIND_SX_BYTE;
         end
         return r;
      end

      // status bytes
      if (b[7]) begin
         if (b < BYTE_F0) begin
            run_status_q = b;
            held0_q = b;
            count_q = 1;
            mode_q = MODE_CHANNEL;
            return r;
         end
         run_status_q = NO_STATUS;
         case (b)
            BYTE_F0: begin
               mode_q = MODE_EXCL;
               count_q = 1;
               r.kind = KIND_SX_BYTE;
               r.sysex_data = b;
            end
            BYTE_F1, BYTE_F2, BYTE_F3: begin
               held0_q = b;
               count_q = 1;
               mode_q = MODE_COMMON;
            end
            BYTE_F6: begin
               mode_q = MODE_READY;
               count_q = 0;
            end
            default: begin
               mode_q = MODE_READY;
               count_q = 0;
               r.kind = KIND_UNDEF;
            end
         endcase
         return r;
      end

      // data bytes; running status restarts a channel message
      if (mode_q == MODE_READY) begin
         if (run_status_q == NO_STATUS) return r;
         held0_q = run_status_q;
         count_q = 1;
         mode_q = MODE_CHANNEL;
      end
      if (held0_q < BYTE_F0) need = chan_len(held0_q);
      else need = (held0_q == BYTE_F2) ? 3 : 2;
      if (count_q + 1 >= need) begin
         if (mode_q == MODE_CHANNEL) begin
            r.kind = KIND_SHORT;
            if (count_q >= 2) r.short_message = {b, held1_q, held0_q};
            else r.short_message = {8'h00, b, held0_q};
         end
         mode_q = MODE_READY;
         count_q = 0;
      end else begin
         held1_q = b;
         count_q++;
      end
      return r;
   endfunction

   // driver: predict on acceptance, then offer the next pending beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) results_due.push_back(parse_byte(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() > 0 && (steady || $urandom_range(0, 99) >= 9)) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         stall_left <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 9);
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen <= beats_seen + 1;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: expected none, actual kind %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            due_now = results_due.pop_front();
            if (rsp_tuser !== due_now.kind) begin
               errors++;
               $display("%0t result_kind: expected %0d, actual %0d",
                        $time, due_now.kind, rsp_tuser);
            end
            if (rsp_tdata[23:0] !== due_now.short_message) begin
               errors++;
               $display("%0t short_message: expected %h, actual %h",
                        $time, due_now.short_message, rsp_tdata[23:0]);
            end
            if (rsp_tdata[31:24] !== due_now.sysex_data) begin
               errors++;
               $display("%0t sysex_data: expected %h, actual %h",
                        $time, due_now.sysex_data, rsp_tdata[31:24]);
            end
            if (rsp_tdata[43:32] !== due_now.sysex_position) begin
               errors++;
               $display("%0t sysex_position: expected %0d, actual %0d",
                        $time, due_now.sysex_position, rsp_tdata[43:32]);
            end
         end
      end
   end

   function automatic logic [7:0] rt_byte();
      case ($urandom_range(0, 5))
         0: return BYTE_F8;
         1: return BYTE_FA;
         2: return BYTE_FB;
         3: return BYTE_FC;
         4: return BYTE_FE;
         default: return BYTE_FF;
      endcase
   endfunction

   task automatic put(input logic [7:0] b);
      pending_bytes.push_back(b);
      stim_count++;
   endtask

   // wait until every beat is sent and every result is back
   task automatic drain();
      do @(negedge clock);
      while (pending_bytes.size() > 0 || req_tvalid || results_due.size() > 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_port(input logic open);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= open;
      open_q = open;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // mostly well-formed messages with random content, plus noise and broken ones
   task automatic add_traffic(input int n);
      int         stop_at;
      int         pick;
      int         k;
      logic [7:0] st;
      stop_at = stim_count + n;
      while (stim_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            last_status = st;
            put(st);
            for (k = 1; k < chan_len(st); k++) begin
               if ($urandom_range(0, 9) == 0) pending_bytes.push_back(rt_byte());
               put(8'($urandom_range(0, 127)));
            end
         end else if (pick < 55) begin
            // running status, or stray data if the status was cleared
            for (k = 1; k < chan_len(last_status); k++) put(8'($urandom_range(0, 127)));
         end else if (pick < 65) begin
            put(BYTE_F0);
            repeat ($urandom_range(0, 12)) begin
               if ($urandom_range(0, 7) == 0) put(8'($urandom_range(8'h80, 8'hFF)));
               else put(8'($urandom_range(0, 127)));
            end
            put(BYTE_F7);
         end else if (pick < 73) begin
            case ($urandom_range(0, 3))
               0: begin put(BYTE_F1); put(8'($urandom_range(0, 127))); end
               1: begin
                  put(BYTE_F2);
                  put(8'($urandom_range(0, 127)));
                  put(8'($urandom_range(0, 127)));
               end
               2: begin put(BYTE_F3); put(8'($urandom_range(0, 127))); end
               default: put(BYTE_F6);
            endcase
         end else if (pick < 80) begin
            pending_bytes.push_back(rt_byte());
            put(8'($urandom_range(0, 127)));
         end else if (pick < 90) begin
            // message cut short by whatever comes next
            st = 8'($urandom_range(8'h80, 8'hEF));
            last_status = st;
            put(st);
            repeat ($urandom_range(0, chan_len(st) - 2)) put(8'($urandom_range(0, 127)));
         end else begin
            put(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      open_q = 1'b0;
      mode_q = MODE_READY;
      run_status_q = NO_STATUS;
      held0_q = 8'h00;
      held1_q = 8'h00;
      count_q = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // port closed: everything is rejected
      write_port(1'b0);
      put(8'h90); put(8'h40); put(8'h7F); put(BYTE_F0); put(BYTE_F8); put(8'h00);
      drain();

      // directed cases with the port open
      write_port(1'b1);
      put(8'h00);                                   // stray data
      put(8'h80); put(8'h00); put(8'h7F);           // three-byte message
      put(8'hC5); put(8'h12); put(8'h34);           // two-byte, then running status
      put(8'h9F); put(8'h40); put(BYTE_F8); put(8'h7F); // real-time inside a message
      put(BYTE_F1); put(8'h05); put(8'h40);         // common clears running status
      put(BYTE_F2); put(8'h01); put(8'h02);
      put(BYTE_F6);
      put(8'hF4); put(BYTE_F7);                     // undefined status
      put(BYTE_F0); put(8'h80); put(BYTE_FB); put(BYTE_F7); // status forwarded in exclusive
      put(8'hB0); put(8'h10); put(8'hD3); put(8'h20); // new status drops partial message
      drain();

      // random traffic; the receiver hold-off lands in this phase
      add_traffic(450);
      drain();

      // closed again with the parser possibly mid-message
      write_port(1'b0);
      add_traffic(40);
      drain();

      // reopen; traffic and a capacity abort with no idling, then more traffic
      write_port(1'b1);
      steady = 1'b1;
      add_traffic(250);
      put(BYTE_F0);
      repeat (CAPACITY) put(8'($urandom_range(0, 127)));
      drain();
      steady = 1'b0;
      write_port(1'b1);
      add_traffic(250);
      drain();

      repeat (10) @(negedge clock);
      if (errors == 0 && results_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
